/* rtl/trph_pkg.sv */
// Shared types and codes for the task ready priority heap.
`default_nettype none
package trph_pkg;

    localparam int TASK_ID_BITS = 5;
    localparam int COUNT_BITS   = 6;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_UPDATE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } status_t;

    // datapath commands from the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // capture request, read pos of task
        CMD_PUSH_WR,    // write new entry at count
        CMD_POP_MOVE,   // move last entry to slot 0 (read last)
        CMD_RM_MOVE,    // move last entry to idx
        CMD_UPD_WR,     // rewrite keys at idx
        CMD_LOAD_CUR,   // read entry at cur
        CMD_UP_READ,    // read parent of cur
        CMD_UP_STEP,    // compare with parent, swap if better
        CMD_DN_READ,    // read children of cur
        CMD_DN_STEP,    // compare with children, swap with best
        CMD_WRITE_A,    // write pending entry A
        CMD_WRITE_B,    // write pending entry B
        CMD_READ_TOP    // read root for result
    } cmd_t;

    typedef struct packed {
        logic known;
        logic queued;
        logic full;
        logic empty;
        logic idx_is_last;
        logic last_zero;
        logic swap;      // last step found a better entry
        logic at_root;
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/trph_ram.sv */
// Generic single-write, registered-read RAM.
`default_nettype none
module trph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* rtl/trph_datapath.sv */
// Heap storage, position map and the compare/swap logic.
`default_nettype none
module trph_datapath #(
    parameter int HEAP_DEPTH = 32,
    parameter int TASK_COUNT = 32,
    parameter int PRIO_BITS  = 8,
    parameter int STAMP_BITS = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire trph_pkg::cmd_t                 cmd,
    input  wire logic [1:0]                     in_req,
    input  wire logic [4:0]                     in_task,
    input  wire logic                           in_ready,
    input  wire logic [7:0]                     in_prio,
    input  wire logic [31:0]                    in_stamp,
    output trph_pkg::dp_status_t                stat,
    output logic [1:0]                          req_q,
    output logic [4:0]                          popped_task,
    output logic                                top_valid,
    output logic [4:0]                          top_task,
    output logic [5:0]                          count
);
    import trph_pkg::*;

    localparam int HB = $clog2(HEAP_DEPTH);
    localparam int TB = $clog2(TASK_COUNT);
    localparam int CB = $clog2(HEAP_DEPTH + 1);
    localparam int EW = TB + 1 + PRIO_BITS + STAMP_BITS;

    typedef struct packed {
        logic [TB-1:0]         task_id;
        logic                  ready;
        logic [PRIO_BITS-1:0]  prio;
        logic [STAMP_BITS-1:0] stamp;
    } entry_t;

    function automatic logic precedes(entry_t a, entry_t b);
        if (a.ready != b.ready) return a.ready;
        if (a.prio != b.prio) return a.prio < b.prio;
        return a.stamp < b.stamp;
    endfunction

    // request latch
    logic [1:0]            req_reg;
    logic [TB-1:0]         tid_reg;
    logic                  known_reg;
    logic                  rdy_reg;
    logic [PRIO_BITS-1:0]  pri_reg;
    logic [STAMP_BITS-1:0] stm_reg;

    // heap control state
    logic [CB-1:0]         cnt_reg;
    logic [TASK_COUNT-1:0] queued_reg;
    logic [HB-1:0]         cur_reg;
    logic [HB-1:0]         nb_reg;      // swap partner slot
    entry_t                cur_e_reg;   // entry sitting at cur
    entry_t                other_reg;   // entry moving to nb
    logic                  swap_reg;
    logic [4:0]            popped_reg;
    entry_t                lchild_reg;
    logic                  dn_eval_reg; // second half of down step

    // heap RAM, read one slot a cycle
    logic          h_we;
    logic [HB-1:0] h_waddr, h_raddr;
    entry_t        h_wdata, h_rdata;
    logic [EW-1:0] h_rraw;

    trph_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rraw)
    );
    assign h_rdata = entry_t'(h_rraw);

    // position map RAM
    logic          p_we;
    logic [TB-1:0] p_waddr, p_raddr;
    logic [HB-1:0] p_wdata, p_rdata;

    trph_ram #(.WIDTH(HB), .DEPTH(TASK_COUNT)) u_pos (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic [CB-1:0] last_slot;
    logic [HB-1:0] parent, lchild, rchild_addr;
    logic          l_ok, r_ok;
    entry_t        new_e;

    assign last_slot = cnt_reg - CB'(1);
    assign parent    = (cur_reg - HB'(1)) >> 1;
    assign lchild    = HB'({cur_reg, 1'b1});
    assign rchild_addr = lchild + HB'(1);
    assign l_ok = ({1'b0, cur_reg, 1'b1} < (HB + 2)'(cnt_reg));
    assign r_ok = ({1'b0, cur_reg, 1'b1} + (HB + 2)'(1) < (HB + 2)'(cnt_reg));
    assign new_e = '{task_id: tid_reg, ready: rdy_reg, prio: pri_reg, stamp: stm_reg};

    // ram port drive; the heap read port rests on the root
    always_comb
    begin
        h_we = 1'b0; h_waddr = cur_reg; h_wdata = cur_e_reg; h_raddr = '0;
        p_we = 1'b0; p_waddr = cur_e_reg.task_id; p_wdata = cur_reg;
        p_raddr = tid_reg;
        case (cmd)
            CMD_LATCH:                  p_raddr = in_task[TB-1:0];
            CMD_PUSH_WR:
            begin
                h_we = 1'b1; h_waddr = cnt_reg[HB-1:0]; h_wdata = new_e;
                p_we = 1'b1; p_waddr = tid_reg; p_wdata = cnt_reg[HB-1:0];
            end
            CMD_POP_MOVE, CMD_RM_MOVE:  h_raddr = last_slot[HB-1:0];
            CMD_UPD_WR:                 h_raddr = cur_reg;
            CMD_LOAD_CUR:               h_raddr = cur_reg;
            CMD_UP_READ:                h_raddr = parent;
            CMD_DN_READ:                h_raddr = lchild;
            CMD_DN_STEP:                h_raddr = rchild_addr;
            CMD_WRITE_A:
            begin
                h_we = 1'b1; h_waddr = cur_reg; h_wdata = cur_e_reg;
                p_we = 1'b1; p_waddr = cur_e_reg.task_id; p_wdata = cur_reg;
            end
            CMD_WRITE_B:
            begin
                h_we = 1'b1; h_waddr = nb_reg; h_wdata = other_reg;
                p_we = 1'b1; p_waddr = other_reg.task_id; p_wdata = nb_reg;
                h_raddr = '0;
            end
            CMD_READ_TOP:               h_raddr = '0;
            default: ;
        endcase
    end

    // child selection, right child data arrives the cycle after the left
    entry_t best_e;
    logic   best_is_r, best_any;
    always_comb
    begin
        best_e = cur_e_reg; best_any = 1'b0; best_is_r = 1'b0;
        if (l_ok && precedes(lchild_reg, best_e))
        begin
            best_e = lchild_reg; best_any = 1'b1;
        end
        if (r_ok && precedes(h_rdata, best_e))
        begin
            best_e = h_rdata; best_any = 1'b1; best_is_r = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg     <= '0;
            tid_reg     <= '0;
            known_reg   <= 1'b0;
            rdy_reg     <= 1'b0;
            pri_reg     <= '0;
            stm_reg     <= '0;
            cnt_reg     <= '0;
            queued_reg  <= '0;
            cur_reg     <= '0;
            nb_reg      <= '0;
            cur_e_reg   <= '0;
            other_reg   <= '0;
            swap_reg    <= 1'b0;
            popped_reg  <= '0;
            lchild_reg  <= '0;
            dn_eval_reg <= 1'b0;
        end
        else
        begin
            dn_eval_reg <= (cmd == CMD_DN_STEP);
            case (cmd)
                CMD_NONE:
                begin
                    // child moves up into cur, moving entry goes down a level
                    if (dn_eval_reg && best_any)
                    begin
                        other_reg <= best_e;
                        nb_reg    <= cur_reg;
                        cur_reg   <= best_is_r ? rchild_addr : lchild;
                    end
                end
                CMD_LATCH:
                begin
                    req_reg   <= in_req;
                    tid_reg   <= in_task[TB-1:0];
                    known_reg <= (32'(in_task) < 32'(TASK_COUNT));
                    rdy_reg   <= in_ready;
                    pri_reg   <= in_prio[PRIO_BITS-1:0];
                    stm_reg   <= in_stamp[STAMP_BITS-1:0];
                    popped_reg <= '0;
                end
                CMD_PUSH_WR:
                begin
                    queued_reg[tid_reg] <= 1'b1;
                    cur_reg <= cnt_reg[HB-1:0];
                    cur_e_reg <= new_e;
                    cnt_reg <= cnt_reg + CB'(1);
                end
                CMD_POP_MOVE:
                begin
                    // root read the cycle before is in h_rdata
                    popped_reg <= 5'(h_rdata.task_id);
                    queued_reg[h_rdata.task_id] <= 1'b0;
                    cnt_reg <= last_slot;
                    cur_reg <= '0;
                end
                CMD_RM_MOVE:
                begin
                    queued_reg[tid_reg] <= 1'b0;
                    cnt_reg <= last_slot;
                    cur_reg <= p_rdata;
                end
                CMD_UPD_WR:
                begin
                    cur_reg <= p_rdata;
                    cur_e_reg <= new_e;
                end
                CMD_LOAD_CUR:
                begin
                    // last entry, read by the move the cycle before
                    cur_e_reg <= h_rdata;
                end
                CMD_UP_READ: ;
                CMD_UP_STEP:
                begin
                    swap_reg <= precedes(cur_e_reg, h_rdata);
                    other_reg <= h_rdata;
                    nb_reg <= cur_reg;
                    if (precedes(cur_e_reg, h_rdata))
                    begin
                        cur_reg <= parent;
                    end
                end
                CMD_DN_READ:
                begin
                    swap_reg <= 1'b0;
                end
                CMD_DN_STEP:
                begin
                    lchild_reg <= h_rdata;
                end
                CMD_WRITE_A: ;
                CMD_WRITE_B:
                begin
                    swap_reg <= 1'b0;
                end
                CMD_READ_TOP: ;
                default: ;
            endcase
        end
    end

    assign stat.known       = known_reg;
    assign stat.queued      = queued_reg[tid_reg];
    assign stat.full        = (cnt_reg == CB'(HEAP_DEPTH));
    assign stat.empty       = (cnt_reg == '0);
    assign stat.idx_is_last = (CB'(p_rdata) == last_slot);
    assign stat.last_zero   = (cnt_reg == CB'(1));
    assign stat.swap        = dn_eval_reg ? best_any : swap_reg;
    assign stat.at_root     = (cur_reg == '0);

    assign req_q       = req_reg;
    assign popped_task = popped_reg;
    assign top_valid   = (cnt_reg != '0);
    assign top_task    = (cnt_reg != '0) ? 5'(h_rdata.task_id) : 5'd0;
    assign count       = 6'(cnt_reg);
endmodule
`default_nettype wire

/* rtl/trph_ctrl.sv */
// Controller sequencing one heap request at a time.
`default_nettype none
module trph_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 out_free,
    input  wire trph_pkg::dp_status_t stat,
    input  wire logic [1:0]           req_q,
    output trph_pkg::cmd_t            cmd,
    output logic                      busy,
    output logic [1:0]                res_status,
    output logic                      res_load
);
    import trph_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_POP_RD, S_POP_MV, S_RM_MV, S_MV_LD, S_UPD,
        S_UP_LOAD, S_UP_RD, S_UP_CMP, S_UP_WA, S_UP_WB,
        S_DN_LOAD, S_DN_RD, S_DN_RR, S_DN_EVAL, S_DN_WA, S_DN_WB,
        S_TOP, S_RESULT
    } state_t;

    state_t   state_reg, state_next;
    logic [1:0] st_reg, st_next;
    logic     dn_after_reg, dn_after_next;

    always_comb
    begin
        state_next = state_reg; st_next = st_reg; dn_after_next = dn_after_reg;
        cmd = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd = CMD_LATCH; state_next = S_DECODE; st_next = ST_OK;
                end
            end
            S_DECODE:
            begin
                cmd = CMD_READ_TOP; // root for pop
                state_next = S_TOP;
                case (req_q)
                    REQ_PUSH:
                        if (!stat.known || stat.full || stat.queued) st_next = ST_FULL;
                        else
                        begin
                            cmd = CMD_PUSH_WR; dn_after_next = 1'b0;
                            state_next = S_UP_RD;
                        end
                    REQ_POP:
                        if (stat.empty) st_next = ST_EMPTY;
                        else state_next = S_POP_MV;
                    default:
                        if (!stat.known || !stat.queued) st_next = ST_NOT_QUEUED;
                        else if (req_q == REQ_REMOVE) state_next = S_RM_MV;
                        else state_next = S_UPD;
                endcase
            end
            S_POP_MV:
            begin
                cmd = CMD_POP_MOVE;
                state_next = stat.last_zero ? S_POP_RD : S_MV_LD;
                dn_after_next = 1'b1;
            end
            S_POP_RD: begin cmd = CMD_READ_TOP; state_next = S_TOP; end
            S_RM_MV:
            begin
                cmd = CMD_RM_MOVE;
                if (stat.idx_is_last) state_next = S_POP_RD;
                else
                begin
                    state_next = S_MV_LD; dn_after_next = 1'b1;
                end
            end
            // last entry arrives from the RAM, pop sifts down only
            S_MV_LD:
            begin
                cmd = CMD_LOAD_CUR;
                state_next = (req_q == REQ_POP) ? S_DN_WA : S_UP_WA;
            end
            S_UPD:
            begin
                cmd = CMD_UPD_WR; state_next = S_UP_WA; dn_after_next = 1'b1;
            end
            // write moved or rekeyed entry into cur, then sift up
            S_UP_WA:   begin cmd = CMD_WRITE_A; state_next = S_UP_RD; end
            S_UP_RD:
            begin
                if (stat.at_root) state_next = dn_after_reg ? S_DN_RD : S_POP_RD;
                else begin cmd = CMD_UP_READ; state_next = S_UP_CMP; end
            end
            S_UP_CMP:  begin cmd = CMD_UP_STEP; state_next = S_UP_LOAD; end
            S_UP_LOAD:
            begin
                if (stat.swap) begin cmd = CMD_WRITE_B; state_next = S_UP_WB; end
                else state_next = dn_after_reg ? S_DN_RD : S_POP_RD;
            end
            S_UP_WB:   begin cmd = CMD_WRITE_A; state_next = S_UP_RD; end
            S_DN_WA:   begin cmd = CMD_WRITE_A; state_next = S_DN_RD; end
            S_DN_RD:   begin cmd = CMD_DN_READ; state_next = S_DN_RR; end
            S_DN_RR:   begin cmd = CMD_DN_STEP; state_next = S_DN_EVAL; end
            S_DN_EVAL:
            begin
                if (stat.swap) begin state_next = S_DN_WB; end
                else begin cmd = CMD_READ_TOP; state_next = S_TOP; end
            end
            S_DN_WB:   begin cmd = CMD_WRITE_B; state_next = S_DN_LOAD; end
            S_DN_LOAD: begin cmd = CMD_WRITE_A; state_next = S_DN_RD; end
            S_TOP:     state_next = S_RESULT;
            S_RESULT:  if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg <= ST_OK;
            dn_after_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg <= st_next;
            dn_after_reg <= dn_after_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_status = st_reg;
    assign res_load   = (state_reg == S_RESULT) && out_free;
endmodule
`default_nettype wire

/* rtl/task_ready_priority_heap.sv */
// Top level of the task ready priority heap.
//  channel   dir  tdata fields (low bit up)
//  s_axis    in   req_type, task_id, ready_req, priority_req, timestamp
//  m_axis    out  status, popped_task, top_valid, top_task, count
// One request at a time, paced by the sift loop: each level down runs S_DN_RD,
// S_DN_RR, S_DN_EVAL, S_DN_WB, S_DN_LOAD, each level up S_UP_RD, S_UP_CMP,
// S_UP_LOAD, S_UP_WB, with one heap RAM read or write per cycle.
// Reset empties the heap; ready stays low while a request is in work.
// A result register holds the word until the sink takes it; a stalled sink
// adds its stall cycles.
`default_nettype none
module task_ready_priority_heap #(
    parameter int HEAP_DEPTH = 32,
    parameter int TASK_COUNT = 32,
    parameter int PRIO_BITS  = 8,
    parameter int STAMP_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type[1:0], task_id[6:2], ready_req[7], priority_req[15:8],
    // timestamp[47:16]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], popped_task[6:2], top_valid[7], top_task[12:8], count[18:13]
    output logic [23:0]      m_axis_tdata
);
    import trph_pkg::*;

    cmd_t       cmd;
    dp_status_t stat;
    logic [1:0] req_q, res_status;
    logic       busy, res_load, in_fire, top_valid;
    logic [4:0] popped_task, top_task;
    logic [5:0] count;
    logic       out_valid_reg;
    logic [23:0] out_data_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    trph_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_free(!out_valid_reg || m_axis_tready), .stat(stat), .req_q(req_q),
        .cmd(cmd), .busy(busy), .res_status(res_status), .res_load(res_load)
    );

    trph_datapath #(
        .HEAP_DEPTH(HEAP_DEPTH), .TASK_COUNT(TASK_COUNT),
        .PRIO_BITS(PRIO_BITS), .STAMP_BITS(STAMP_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_req(s_axis_tdata[1:0]), .in_task(s_axis_tdata[6:2]),
        .in_ready(s_axis_tdata[7]), .in_prio(s_axis_tdata[15:8]),
        .in_stamp(s_axis_tdata[47:16]),
        .stat(stat), .req_q(req_q), .popped_task(popped_task),
        .top_valid(top_valid), .top_task(top_task), .count(count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= {5'd0, count, top_task, top_valid,
                             (res_status == ST_OK) ? popped_task : 5'd0, res_status};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule
`default_nettype wire

/* rtl/trph_checker.sv */
// Port-level checks for the task ready priority heap.
`default_nettype none
module trph_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped while stalled");
    a_top_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7] == (m_axis_tdata[18:13] != 6'd0)))
        else $error("top_valid disagrees with count");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:13] <= 6'd32)
        else $error("count beyond depth");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
endmodule

bind task_ready_priority_heap trph_checker u_trph_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

/* sim/task_ready_priority_heap_tb.sv */
// Self-checking testbench for the task ready priority heap.
`default_nettype none
module task_ready_priority_heap_tb;
    import trph_pkg::*;

    localparam int DEPTH     = 32;
    localparam int NTASK     = 32;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] stamp;
        logic [7:0]  prio;
        logic        ready;
        logic [4:0]  task_id;
        logic [1:0]  req;
    } req_word_t;

    typedef struct packed {
        logic [4:0] pad;
        logic [5:0] count;
        logic [4:0] top_task;
        logic       top_valid;
        logic [4:0] popped;
        logic [1:0] status;
    } rsp_word_t;

    typedef struct packed {
        logic [4:0]  task_id;
        logic        ready;
        logic [7:0]  prio;
        logic [31:0] stamp;
    } entry_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    task_ready_priority_heap uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted heap state
    entry_t     heap_q [DEPTH];
    logic [5:0] slot_of [NTASK];
    logic       queued [NTASK];
    int         held;

    req_word_t  pending_reqs [$];
    rsp_word_t  expected_rsps [$];
    int         errors = 0;
    int         sent = 0;
    int         checked = 0;
    int         cycles = 0;
    int         in_gap = 0;
    int         out_gap = 0;

    function automatic bit ahead(entry_t a, entry_t b);
        if (a.ready != b.ready) return a.ready;
        if (a.prio != b.prio) return a.prio < b.prio;
        return a.stamp < b.stamp;
    endfunction

    function automatic void swap_slots(int i, int j);
        entry_t t;
        t = heap_q[i];
        heap_q[i] = heap_q[j];
        heap_q[j] = t;
        slot_of[heap_q[i].task_id] = 6'(i);
        slot_of[heap_q[j].task_id] = 6'(j);
    endfunction

    function automatic int bubble_up(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ahead(heap_q[i], heap_q[p])) break;
            swap_slots(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic void bubble_down(int i);
        int best, l, r;
        forever
        begin
            best = i;
            l = 2 * i + 1;
            r = l + 1;
            if (l < held && ahead(heap_q[l], heap_q[best])) best = l;
            if (r < held && ahead(heap_q[r], heap_q[best])) best = r;
            if (best == i) break;
            swap_slots(i, best);
            i = best;
        end
    endfunction

    function automatic rsp_word_t heap_apply(req_word_t w);
        rsp_word_t o;
        int idx, last;
        o = '0;
        o.status = ST_OK;
        case (req_t'(w.req))
            REQ_PUSH:
                if (held >= DEPTH || queued[w.task_id]) o.status = ST_FULL;
                else
                begin
                    heap_q[held] = '{w.task_id, w.ready, w.prio, w.stamp};
                    slot_of[w.task_id] = 6'(held);
                    queued[w.task_id] = 1'b1;
                    held++;
                    void'(bubble_up(held - 1));
                end
            REQ_POP:
                if (held == 0) o.status = ST_EMPTY;
                else
                begin
                    o.popped = heap_q[0].task_id;
                    queued[heap_q[0].task_id] = 1'b0;
                    held--;
                    if (held != 0)
                    begin
                        heap_q[0] = heap_q[held];
                        slot_of[heap_q[0].task_id] = 6'd0;
                        bubble_down(0);
                    end
                end
            REQ_REMOVE:
                if (!queued[w.task_id]) o.status = ST_NOT_QUEUED;
                else
                begin
                    idx = slot_of[w.task_id];
                    last = held - 1;
                    queued[w.task_id] = 1'b0;
                    held = last;
                    if (idx != last)
                    begin
                        heap_q[idx] = heap_q[last];
                        slot_of[heap_q[idx].task_id] = 6'(idx);
                        void'(bubble_up(idx));
                        bubble_down(idx);
                    end
                end
            default:
                if (!queued[w.task_id]) o.status = ST_NOT_QUEUED;
                else
                begin
                    idx = slot_of[w.task_id];
                    heap_q[idx].ready = w.ready;
                    heap_q[idx].prio = w.prio;
                    heap_q[idx].stamp = w.stamp;
                    idx = bubble_up(idx);
                    bubble_down(idx);
                end
        endcase
        o.top_valid = held != 0;
        o.top_task = held != 0 ? heap_q[0].task_id : 5'd0;
        o.count = 6'(held);
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on word %0d: %s got %0d expected %0d", checked, what, got, want);
    endtask

    // few keys so ties happen often
    function automatic req_word_t mk(req_t r, int tid);
        req_word_t w;
        w.req = r;
        w.task_id = 5'(tid);
        w.ready = 1'($urandom_range(0, 1));
        w.prio = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
        w.stamp = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 3));
        return w;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (in_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_reqs.pop_front();
                in_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            end
            else
                s_axis_tvalid <= 1'b0;
            if (out_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_word_t got, want;
        cycles <= cycles + 1;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_rsps.push_back(heap_apply(req_word_t'(s_axis_tdata)));
            sent <= sent + 1;
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = rsp_word_t'(m_axis_tdata);
            if (expected_rsps.size() == 0)
                report("unexpected word", 32'(m_axis_tdata), 32'd0);
            else
            begin
                want = expected_rsps.pop_front();
                if (got.status !== want.status)
                    report("status", 32'(got.status), 32'(want.status));
                if (got.popped !== want.popped)
                    report("popped_task", 32'(got.popped), 32'(want.popped));
                if (got.top_valid !== want.top_valid)
                    report("top_valid", 32'(got.top_valid), 32'(want.top_valid));
                if (got.top_task !== want.top_task)
                    report("top_task", 32'(got.top_task), 32'(want.top_task));
                if (got.count !== want.count)
                    report("count", 32'(got.count), 32'(want.count));
            end
            checked <= checked + 1;
            out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        end
    end

    initial
    begin
        int k, mode, tid;
        held = 0;
        for (k = 0; k < NTASK; k++)
        begin
            queued[k] = 1'b0;
            slot_of[k] = '0;
        end
        // directed: empty cases, extremes, fill past full, then pops from the full heap
        pending_reqs.push_back(mk(REQ_POP, 0));
        pending_reqs.push_back(mk(REQ_REMOVE, 31));
        pending_reqs.push_back(mk(REQ_UPDATE, 0));
        pending_reqs.push_back('{32'hFFFF_FFFF, 8'hFF, 1'b0, 5'd31, REQ_PUSH});
        pending_reqs.push_back('{32'h0, 8'h0, 1'b1, 5'd0, REQ_PUSH});
        pending_reqs.push_back('{32'h0, 8'h0, 1'b1, 5'd0, REQ_PUSH});
        pending_reqs.push_back('{32'h5, 8'h0, 1'b1, 5'd7, REQ_PUSH});
        pending_reqs.push_back('{32'h0, 8'h0, 1'b1, 5'd9, REQ_PUSH});
        pending_reqs.push_back('{32'h0, 8'h0, 1'b1, 5'd10, REQ_PUSH});
        pending_reqs.push_back('{32'h1, 8'h80, 1'b1, 5'd31, REQ_UPDATE});
        pending_reqs.push_back(mk(REQ_REMOVE, 10));
        pending_reqs.push_back(mk(REQ_REMOVE, 0));
        for (k = 0; k < NTASK; k++) pending_reqs.push_back(mk(REQ_PUSH, k));
        pending_reqs.push_back(mk(REQ_PUSH, 3));
        for (k = 0; k < 5; k++) pending_reqs.push_back(mk(REQ_POP, 0));
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // random: mostly valid ops on a small pool of tasks
        for (k = 0; k < 2000; k++)
        begin
            mode = $urandom_range(0, 9);
            tid = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 11);
            if (mode < 4) pending_reqs.push_back(mk(REQ_PUSH, tid));
            else if (mode < 6) pending_reqs.push_back(mk(REQ_POP, tid));
            else if (mode < 8) pending_reqs.push_back(mk(REQ_UPDATE, tid));
            else pending_reqs.push_back(mk(REQ_REMOVE, tid));
            if (k % 400 == 399)
                repeat (30) pending_reqs.push_back(mk(REQ_POP, 0));
        end
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
        begin
            @(posedge clk);
            if (cycles > CYC_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
        repeat (50) @(posedge clk);
        $display("%0d requests sent, %0d results checked over push/pop/remove/update",
                 sent, checked);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
